[design/canonical_huffman_decode_macros.svh]
// Assertion helpers used by the chd_back RTL file.
`ifndef CANONICAL_HUFFMAN_DECODE_MACROS_SVH
`define CANONICAL_HUFFMAN_DECODE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CHD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define CHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/chd_pkg.sv]
package chd_pkg;

    localparam int ALPHA    = 256;
    localparam int ABITS    = $clog2(ALPHA);
    localparam int IDX_W    = $clog2(ALPHA + 1);
    localparam int SYM_W    = 8;
    localparam int LEN_W    = 5;
    localparam int LEN_N    = 1 << LEN_W;
    localparam int MAX_LEN  = 31;
    localparam int CNT_W    = 9;
    localparam int CODE_W   = 32;
    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_DATA  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_ERR = 1'b1;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_LOAD,
        OP_DATA
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [SYM_W-1:0] sym;
        logic [LEN_W-1:0] len;
        logic [7:0]       data;
    } t_cmd;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             status;
        logic             finished;
        logic             last;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OFFS,
        ST_FILL,
        ST_BIT,
        ST_FETCH,
        ST_DONE
    } t_state;

endpackage

[design/chd_ram.sv]
module chd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[design/chd_front.sv]
module chd_front import chd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [1:0]       i_mode,
    input  logic [SYM_W-1:0] i_entry_symbol,
    input  logic [LEN_W-1:0] i_entry_length,
    input  logic [7:0]       i_data_byte,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output t_cmd             o_cmd
);

    t_cmd             r_q [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wp, r_rp;
    logic [CQ_AW:0]   r_cnt;
    logic             known;
    logic             wr, rd;
    t_cmd             cmd;

    always_comb begin
        known = 1'b1;
        cmd   = '{op: OP_DATA, sym: i_entry_symbol, len: i_entry_length, data: i_data_byte};
        case (i_mode)
            MODE_CLEAR: cmd.op = OP_CLEAR;
            MODE_LOAD:  cmd.op = OP_LOAD;
            MODE_DATA:  cmd.op = OP_DATA;
            default:    known  = 1'b0;
        endcase
    end

    assign o_full  = (r_cnt == (CQ_AW + 1)'(CQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rp];
    assign wr      = i_push && !o_full && known;
    assign rd      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + CQ_AW'(1);
            end
            if (rd) begin
                r_rp <= r_rp + CQ_AW'(1);
            end
            r_cnt <= r_cnt + (CQ_AW + 1)'(wr) - (CQ_AW + 1)'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= cmd;
        end
    end

endmodule

[design/chd_out.sv]
module chd_out import chd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_res,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_res o_res
);

    t_res             r_q [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wp, r_rp;
    logic [OQ_AW:0]   r_cnt;
    logic             wr, rd;

    assign o_full  = (r_cnt == (OQ_AW + 1)'(OQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_res   = r_q[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + OQ_AW'(1);
            end
            if (rd) begin
                r_rp <= r_rp + OQ_AW'(1);
            end
            r_cnt <= r_cnt + (OQ_AW + 1)'(wr) - (OQ_AW + 1)'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= i_res;
        end
    end

endmodule

[design/chd_back.sv]
`include "canonical_huffman_decode_macros.svh"

module chd_back import chd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CODE_W-1:0] i_cfg_wdata,
    input  logic              i_cq_valid,
    input  t_cmd              i_cmd,
    output logic              o_cq_pop,
    input  logic              i_oq_full,
    output logic              o_push,
    output t_res              o_res
);

    t_state r_state, n_state;

    logic [CODE_W-1:0] r_count_cfg;
    logic [ALPHA-1:0]  r_present, n_present;
    logic [CNT_W-1:0]  r_cnt [LEN_N];
    logic [CNT_W-1:0]  n_cnt [LEN_N];
    logic [CNT_W-1:0]  r_offset [LEN_N];
    logic [CNT_W-1:0]  n_offset [LEN_N];
    logic [CNT_W-1:0]  r_fill [LEN_N];
    logic [CNT_W-1:0]  n_fill [LEN_N];
    logic [CODE_W-1:0] r_first [LEN_N];
    logic [CODE_W-1:0] n_first [LEN_N];
    logic              r_built, n_built;
    logic [CODE_W-1:0] r_shift, n_shift;
    logic [LEN_W-1:0]  r_bits, n_bits;
    logic [CODE_W-1:0] r_left, n_left;
    logic              r_zero_seen, n_zero_seen;
    logic              r_used, n_used;
    logic [SYM_W-1:0]  r_lone, n_lone;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CODE_W-1:0] r_next, n_next;
    logic [CNT_W-1:0]  r_off, n_off;
    logic [7:0]        r_byte, n_byte;
    logic [3:0]        r_nbits, n_nbits;
    logic [ABITS-1:0]  r_faddr, n_faddr;
    logic              r_pend_vld, n_pend_vld;
    t_res              r_pend, n_pend;

    logic              lone_vld;
    logic [IDX_W-1:0]  idx_m1;
    logic [ABITS-1:0]  scan_sym;
    logic [LEN_W-1:0]  len_rd;
    logic              len_ok;
    logic              bit_in;
    logic [LEN_W-1:0]  lnext;
    logic [CODE_W-1:0] shift_in;
    logic [CODE_W-1:0] diff;
    logic              match;
    logic              overflow;
    logic [ABITS-1:0]  faddr_c;
    logic              prod;
    t_res              prod_res;
    logic              go;
    logic              len_we;
    logic [LEN_W-1:0]  len_rdata;
    logic [SYM_W-1:0]  sort_rdata;
    logic              sort_we;
    logic [ABITS-1:0]  sort_waddr;

    assign lone_vld = r_zero_seen && !r_used;
    assign idx_m1   = r_idx - IDX_W'(1);
    assign scan_sym = idx_m1[ABITS-1:0];
    assign len_rd   = len_rdata;
    assign len_ok   = (len_rd != '0) && ({1'b0, len_rd} <= (LEN_W + 1)'(MAX_LEN));
    assign bit_in   = r_byte[3'(r_nbits - 4'd1)];
    assign lnext    = r_bits + LEN_W'(1);
    assign shift_in = {r_shift[CODE_W-2:0], bit_in};
    assign diff     = shift_in - r_first[lnext];
    assign match    = ({1'b0, lnext} <= (LEN_W + 1)'(MAX_LEN)) && (r_cnt[lnext] != '0)
                      && (diff < CODE_W'(r_cnt[lnext]));
    assign overflow = !match && ({1'b0, lnext} >= (LEN_W + 1)'(MAX_LEN));
    assign faddr_c  = r_offset[lnext][ABITS-1:0] + diff[ABITS-1:0];

    always_comb begin
        prod     = 1'b0;
        prod_res = '{symbol: '0, status: STAT_OK, finished: 1'b0, last: 1'b0};
        case (r_state)
            ST_BIT: begin
                if (r_left != '0) begin
                    if (lone_vld) begin
                        prod            = 1'b1;
                        prod_res.symbol = r_lone;
                        prod_res.finished = (r_left == CODE_W'(1));
                    end else if (overflow) begin
                        prod            = 1'b1;
                        prod_res.status = STAT_ERR;
                    end
                end
            end
            ST_FETCH: begin
                prod              = 1'b1;
                prod_res.symbol   = sort_rdata;
                prod_res.finished = (r_left == CODE_W'(1));
            end
            default: prod = 1'b0;
        endcase
    end

    assign go = !(prod && r_pend_vld && i_oq_full);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cq_valid && i_cmd.op == OP_DATA) begin
                    n_state = r_built ? ST_BIT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == IDX_W'(ALPHA)) begin
                    n_state = ST_OFFS;
                end
            end
            ST_OFFS: begin
                if (r_idx == IDX_W'(MAX_LEN)) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                if (r_idx == IDX_W'(ALPHA)) begin
                    n_state = ST_BIT;
                end
            end
            ST_BIT: begin
                if (r_left == '0) begin
                    n_state = ST_DONE;
                end else if (!lone_vld && match) begin
                    n_state = ST_FETCH;
                end else if (go) begin
                    n_state = (r_nbits == 4'd1) ? ST_DONE : ST_BIT;
                end
            end
            ST_FETCH: begin
                if (go) begin
                    n_state = (r_nbits == 4'd1) ? ST_DONE : ST_BIT;
                end
            end
            ST_DONE: begin
                if (!r_pend_vld || !i_oq_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_present   = r_present;
        n_cnt       = r_cnt;
        n_offset    = r_offset;
        n_fill      = r_fill;
        n_first     = r_first;
        n_built     = r_built;
        n_shift     = r_shift;
        n_bits      = r_bits;
        n_left      = r_left;
        n_zero_seen = r_zero_seen;
        n_used      = r_used;
        n_lone      = r_lone;
        n_idx       = r_idx;
        n_next      = r_next;
        n_off       = r_off;
        n_byte      = r_byte;
        n_nbits     = r_nbits;
        n_faddr     = r_faddr;
        n_pend_vld  = r_pend_vld;
        n_pend      = r_pend;
        o_cq_pop    = 1'b0;
        o_push      = 1'b0;
        o_res       = r_pend;
        len_we      = 1'b0;
        sort_we     = 1'b0;
        sort_waddr  = r_fill[len_rd][ABITS-1:0];

        case (r_state)
            ST_IDLE: begin
                o_cq_pop = i_cq_valid;
                if (i_cq_valid) begin
                    case (i_cmd.op)
                        OP_CLEAR: begin
                            n_present = '0;
                            n_built   = 1'b0;
                            n_shift   = '0;
                            n_bits    = '0;
                            n_left    = '0;
                        end
                        OP_LOAD: begin
                            if (int'(i_cmd.sym) < ALPHA) begin
                                len_we = 1'b1;
                                n_present[i_cmd.sym[ABITS-1:0]] = 1'b1;
                            end
                            n_built = 1'b0;
                        end
                        OP_DATA: begin
                            n_byte  = i_cmd.data;
                            n_nbits = 4'd8;
                            n_idx   = '0;
                            if (!r_built) begin
                                for (int i = 0; i < LEN_N; i++) begin
                                    n_cnt[i] = '0;
                                end
                                n_zero_seen = 1'b0;
                                n_used      = 1'b0;
                                n_lone      = '0;
                            end
                        end
                        default: n_built = r_built;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_idx != '0 && r_present[scan_sym]) begin
                    if (len_rd == '0) begin
                        if (!r_zero_seen) begin
                            n_zero_seen = 1'b1;
                            n_lone      = SYM_W'(scan_sym);
                        end
                    end else if (len_ok) begin
                        n_cnt[len_rd] = r_cnt[len_rd] + CNT_W'(1);
                        n_used        = 1'b1;
                    end
                end
                if (r_idx == IDX_W'(ALPHA)) begin
                    n_idx  = IDX_W'(1);
                    n_next = '0;
                    n_off  = '0;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_OFFS: begin
                n_offset[r_idx[LEN_W-1:0]] = r_off;
                n_fill[r_idx[LEN_W-1:0]]   = r_off;
                n_first[r_idx[LEN_W-1:0]]  = r_next;
                n_off  = r_off + r_cnt[r_idx[LEN_W-1:0]];
                n_next = CODE_W'((r_next + CODE_W'(r_cnt[r_idx[LEN_W-1:0]])) << 1);
                n_idx  = (r_idx == IDX_W'(MAX_LEN)) ? '0 : r_idx + IDX_W'(1);
            end
            ST_FILL: begin
                if (r_idx != '0 && r_present[scan_sym] && len_ok) begin
                    sort_we        = 1'b1;
                    n_fill[len_rd] = r_fill[len_rd] + CNT_W'(1);
                end
                if (r_idx == IDX_W'(ALPHA)) begin
                    n_shift = '0;
                    n_bits  = '0;
                    n_left  = r_count_cfg;
                    n_built = 1'b1;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_BIT: begin
                if (r_left != '0 && go) begin
                    if (lone_vld) begin
                        n_left  = r_left - CODE_W'(1);
                        n_nbits = r_nbits - 4'd1;
                    end else if (match) begin
                        n_faddr = faddr_c;
                        n_shift = '0;
                        n_bits  = '0;
                    end else if (overflow) begin
                        n_shift = '0;
                        n_bits  = '0;
                        n_nbits = r_nbits - 4'd1;
                    end else begin
                        n_shift = shift_in;
                        n_bits  = lnext;
                        n_nbits = r_nbits - 4'd1;
                    end
                end
            end
            ST_FETCH: begin
                if (go) begin
                    n_left  = r_left - CODE_W'(1);
                    n_nbits = r_nbits - 4'd1;
                end
            end
            ST_DONE: begin
                if (r_pend_vld && !i_oq_full) begin
                    o_push     = 1'b1;
                    o_res.last = 1'b1;
                    n_pend_vld = 1'b0;
                end
            end
            default: n_built = r_built;
        endcase

        if (prod && go) begin
            o_push     = r_pend_vld;
            n_pend_vld = 1'b1;
            n_pend     = prod_res;
        end
    end

    chd_ram #(.WIDTH(LEN_W), .DEPTH(ALPHA)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (i_cmd.sym[ABITS-1:0]),
        .i_wdata (i_cmd.len),
        .i_raddr (r_idx[ABITS-1:0]),
        .o_rdata (len_rdata)
    );

    chd_ram #(.WIDTH(SYM_W), .DEPTH(ALPHA)) u_sort_ram (
        .i_clk   (i_clk),
        .i_we    (sort_we),
        .i_waddr (sort_waddr),
        .i_wdata (SYM_W'(scan_sym)),
        .i_raddr ((r_state == ST_FETCH) ? r_faddr : faddr_c),
        .o_rdata (sort_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count_cfg <= '0;
            r_present   <= '0;
            r_built     <= 1'b0;
            r_shift     <= '0;
            r_bits      <= '0;
            r_left      <= '0;
            r_zero_seen <= 1'b0;
            r_used      <= 1'b0;
            r_pend_vld  <= 1'b0;
            for (int i = 0; i < LEN_N; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_present   <= n_present;
            r_built     <= n_built;
            r_shift     <= n_shift;
            r_bits      <= n_bits;
            r_left      <= n_left;
            r_zero_seen <= n_zero_seen;
            r_used      <= n_used;
            r_pend_vld  <= n_pend_vld;
            r_cnt       <= n_cnt;
            if (i_cfg_we) begin
                r_count_cfg <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_offset <= n_offset;
        r_fill   <= n_fill;
        r_first  <= n_first;
        r_lone   <= n_lone;
        r_idx    <= n_idx;
        r_next   <= n_next;
        r_off    <= n_off;
        r_byte   <= n_byte;
        r_nbits  <= n_nbits;
        r_faddr  <= n_faddr;
        r_pend   <= n_pend;
    end

    `CHD_ASSERT_NOW(a_push_not_full, i_clk, i_rst_n, o_push, !i_oq_full)
    `CHD_ASSERT_NOW(a_last_in_done, i_clk, i_rst_n, o_push && o_res.last, r_state == ST_DONE)
    `CHD_ASSERT_NEXT(a_fetch_after_bit, i_clk, i_rst_n,
        r_state == ST_BIT && n_state == ST_FETCH, r_bits == '0 && r_shift == '0)

endmodule

[design/canonical_huffman_decode.sv]
// Canonical Huffman decoder.
// Input queue: drive mode and its fields with push; a beat is taken when
// push is high and full low. Mode 0 clears the table, mode 1 loads one
// (symbol, length) entry, mode 2 is a data byte; mode 3 is taken and dropped.
// Result queue: while empty is low the oldest result is on the o_ ports;
// it is taken when pop is high. last_of_byte marks a byte's final result.
// Configuration: write symbol_count with i_cfg_we/i_cfg_wdata while idle.
// Sequence: clear and load are handled in the idle state. The first data
// byte after a table change first builds the code: two sweeps of the
// 256-entry length RAM plus one step per code length. A data byte then
// leaves the input queue, each of its bits is examined in turn, each matched
// code adds a read of the sorted symbol RAM, and a closing state ends it; a
// result reaches the queue one code later or when the byte ends. A 2-beat
// input queue and a 4-beat result queue decouple both sides; a stalled
// receiver halts decoding once the result queue is full.
// Reset empties both queues, the table and the count.
module canonical_huffman_decode import chd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_mode,
    input  logic [SYM_W-1:0]  i_entry_symbol,
    input  logic [LEN_W-1:0]  i_entry_length,
    input  logic [7:0]        i_data_byte,
    output logic              empty,
    input  logic              pop,
    output logic [SYM_W-1:0]  o_decoded_symbol,
    output logic              o_status,
    output logic              o_finished,
    output logic              o_last_of_byte,
    input  logic              i_cfg_we,
    input  logic [CODE_W-1:0] i_cfg_wdata
);

    logic cq_valid, cq_pop, oq_full, oq_push;
    t_cmd cmd;
    t_res res_in, res_out;

    chd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_mode         (i_mode),
        .i_entry_symbol (i_entry_symbol),
        .i_entry_length (i_entry_length),
        .i_data_byte    (i_data_byte),
        .o_full         (full),
        .i_pop          (cq_pop),
        .o_valid        (cq_valid),
        .o_cmd          (cmd)
    );

    chd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cq_valid  (cq_valid),
        .i_cmd       (cmd),
        .o_cq_pop    (cq_pop),
        .i_oq_full   (oq_full),
        .o_push      (oq_push),
        .o_res       (res_in)
    );

    chd_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .i_res   (res_in),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (res_out)
    );

    assign o_decoded_symbol = res_out.symbol;
    assign o_status         = res_out.status;
    assign o_finished       = res_out.finished;
    assign o_last_of_byte   = res_out.last;

endmodule
